[rtl/assert_macros.svh]
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/bapr_pkg.sv]
`timescale 1ns / 1ps

package bapr_pkg;

  // request types
  localparam logic [1:0] REQ_READ    = 2'd0;
  localparam logic [1:0] REQ_WRITE   = 2'd1;
  localparam logic [1:0] REQ_CONSUME = 2'd2;
  localparam logic [1:0] REQ_CLEAR   = 2'd3;

  // register numbers within a pointer set
  localparam logic [2:0] REG_ADDR_HI  = 3'd0;
  localparam logic [2:0] REG_ADDR_LO  = 3'd1;
  localparam logic [2:0] REG_INC_HI   = 3'd2;
  localparam logic [2:0] REG_INC_LO   = 3'd3;
  localparam logic [2:0] REG_MODE     = 3'd4;
  localparam logic [2:0] REG_DUMMY    = 3'd5;
  localparam logic [2:0] REG_DATA     = 3'd6;
  localparam logic [2:0] REG_DATA_INC = 3'd7;

  localparam logic [15:0] STALL_PER_ACCESS = 16'd2;
  localparam logic [15:0] STALL_MAX        = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [4:0]  reg_addr;
    logic [15:0] write_data;
    logic        rmw_access;
    logic [15:0] cycle_budget;
  } bapr_in_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [15:0] cycles_left;
  } bapr_out_t;

  // control from the sequencer to the word port
  typedef struct packed {
    logic        rd_en;
    logic        wr_en;
    logic        capture;
    logic [4:0]  shift;
    logic [31:0] mask;
    logic [15:0] wr_val;
  } bapr_mem_cmd_t;

  // keeps the shift aligned to the field size
  function automatic logic [4:0] pos_mask(input logic [2:0] size);
    logic [4:0] m;
    case (size)
      3'd0:    m = 5'h1F;
      3'd1:    m = 5'h1E;
      3'd2:    m = 5'h1C;
      3'd3:    m = 5'h18;
      default: m = 5'h10;
    endcase
    return m;
  endfunction

  function automatic logic [15:0] field_mask(input logic [2:0] size);
    logic [15:0] m;
    case (size)
      3'd0:    m = 16'h0001;
      3'd1:    m = 16'h0003;
      3'd2:    m = 16'h000F;
      3'd3:    m = 16'h00FF;
      default: m = 16'hFFFF;
    endcase
    return m;
  endfunction

endpackage

[rtl/bapr_word_port.sv]
`timescale 1ns / 1ps

module bapr_word_port #(
  parameter int RAM_WORDS = 65536
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bapr_pkg::bapr_mem_cmd_t      cmd,
  input  logic [$clog2(RAM_WORDS)-1:0] rd_idx,
  output logic [15:0]                  field
);

  localparam int IdxW = $clog2(RAM_WORDS);

  logic [31:0]     ram [RAM_WORDS];
  logic [31:0]     ram_q_r;
  logic [IdxW-1:0] pend_idx_r;

  logic [IdxW-1:0] saved_idx_r;
  logic [31:0]     saved_word_r;
  logic [31:0]     saved_mask_r;
  logic [4:0]      saved_shift_r;

  logic [31:0] merged;
  logic [31:0] field_wide;

  assign field_wide = (ram_q_r & cmd.mask) >> cmd.shift;
  assign field      = field_wide[15:0];

  assign merged = (saved_word_r & ~saved_mask_r) |
                  (({16'b0, cmd.wr_val} << saved_shift_r) & saved_mask_r);

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      ram_q_r    <= ram[rd_idx];
      pend_idx_r <= rd_idx;
    end
    if (cmd.wr_en) begin
      ram[saved_idx_r] <= merged;
    end
  end

  // last data read, used by the next data write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      saved_idx_r   <= '0;
      saved_word_r  <= '0;
      saved_mask_r  <= '0;
      saved_shift_r <= '0;
    end else if (cmd.capture) begin
      saved_idx_r   <= pend_idx_r;
      saved_word_r  <= ram_q_r;
      saved_mask_r  <= cmd.mask;
      saved_shift_r <= cmd.shift;
    end
  end

endmodule

[rtl/bit_addressed_pointer_ram_port_top.sv]
`timescale 1ns / 1ps

// Bit-addressed pointer port onto a RAM of 32-bit words. Four pointer sets of
// eight 16-bit registers (address, increment, size/mode) give field access in
// big-endian bit order through data registers 6 and 7. Every item returns one
// result. Register accesses, data writes, consume and clear requests are answered
// from the output register; a data read first goes through the registered read of the
// synchronous word RAM. The RAM has no reset; reading a word never written gives an
// undefined field. A new item is held off while a result is stalled on the
// output and while a data read is in flight.

module bit_addressed_pointer_ram_port_top #(
  parameter int RAM_WORDS = 65536
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bapr_pkg::bapr_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bapr_pkg::bapr_out_t out_data
);

  localparam int IdxW = $clog2(RAM_WORDS);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_FETCH = 1'b1;

  logic state_r, state_nxt;

  // pointer sets
  logic [15:0] addr_hi_r [4];
  logic [15:0] addr_lo_r [4];
  logic [8:0]  inc_hi_r  [4];
  logic [15:0] inc_lo_r  [4];
  logic [3:0]  mode_r    [4];

  logic [1:0]  set_r, set_nxt;
  logic        post_inc_r, post_inc_nxt;
  logic [15:0] stall_cnt_r, stall_cnt_nxt;
  logic        out_valid_r, out_valid_nxt;
  bapr_pkg::bapr_out_t out_data_r, out_data_nxt;

  logic        ptr_we;
  logic [1:0]  ptr_set;
  logic [2:0]  ptr_reg;
  logic [15:0] ptr_val;
  logic        adv_we;
  logic [31:0] adv_addr;

  bapr_pkg::bapr_mem_cmd_t mem_cmd;
  logic [IdxW-1:0]         rd_idx;
  logic [15:0]             field;

  logic        accept;
  logic [1:0]  in_set;
  logic [2:0]  in_reg;
  logic        in_is_data;
  logic [31:0] in_addr;
  logic [15:0] reg_rdata;
  logic [31:0] cur_addr;
  logic [2:0]  cur_size;
  logic [4:0]  cur_shift;
  logic [15:0] stall_add;
  logic        out_free;

  assign in_stall  = (state_r == ST_FETCH) || (out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_set     = in_data.reg_addr[4:3];
  assign in_reg     = in_data.reg_addr[2:0];
  assign in_is_data = (in_reg[2:1] == 2'b11);
  assign in_addr    = {addr_hi_r[in_set], addr_lo_r[in_set]};
  assign rd_idx     = in_addr[5 +: IdxW];

  assign cur_addr  = {addr_hi_r[set_r], addr_lo_r[set_r]};
  assign cur_size  = mode_r[set_r][2:0];
  assign cur_shift = (5'h1F - cur_addr[4:0]) & bapr_pkg::pos_mask(cur_size);
  assign adv_addr  = cur_addr + {7'b0, inc_hi_r[set_r], inc_lo_r[set_r]};

  assign stall_add = (stall_cnt_r >= (bapr_pkg::STALL_MAX - bapr_pkg::STALL_PER_ACCESS)) ?
                     bapr_pkg::STALL_MAX : stall_cnt_r + bapr_pkg::STALL_PER_ACCESS;

  always_comb begin
    unique case (in_reg)
      bapr_pkg::REG_ADDR_HI: reg_rdata = addr_hi_r[in_set];
      bapr_pkg::REG_ADDR_LO: reg_rdata = addr_lo_r[in_set];
      bapr_pkg::REG_INC_HI:  reg_rdata = {7'b0, inc_hi_r[in_set]};
      bapr_pkg::REG_INC_LO:  reg_rdata = inc_lo_r[in_set];
      bapr_pkg::REG_MODE:    reg_rdata = {12'b0, mode_r[in_set]};
      default:               reg_rdata = 16'h0000;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    set_nxt       = set_r;
    post_inc_nxt  = post_inc_r;
    stall_cnt_nxt = stall_cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    ptr_we        = 1'b0;
    ptr_set       = in_set;
    ptr_reg       = in_reg;
    ptr_val       = in_data.write_data;
    adv_we        = 1'b0;
    mem_cmd       = '0;
    mem_cmd.shift = cur_shift;
    mem_cmd.mask  = {16'b0, bapr_pkg::field_mask(cur_size)} << cur_shift;
    mem_cmd.wr_val = in_data.write_data;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          unique case (in_data.req_type)
            bapr_pkg::REQ_READ: begin
              if (in_is_data) begin
                mem_cmd.rd_en = 1'b1;
                out_valid_nxt = 1'b0;
                set_nxt       = in_set;
                // mode bit 3 blocks the increment unless part of a read-modify-write
                post_inc_nxt  = in_reg[0] && (!mode_r[in_set][3] || in_data.rmw_access);
                state_nxt     = ST_FETCH;
              end else begin
                out_data_nxt.read_data = reg_rdata;
              end
            end
            bapr_pkg::REQ_WRITE: begin
              if (in_is_data) begin
                mem_cmd.wr_en = 1'b1;
                stall_cnt_nxt = stall_add;
              end else begin
                ptr_we = 1'b1;
              end
            end
            bapr_pkg::REQ_CONSUME: begin
              if (stall_cnt_r > in_data.cycle_budget) begin
                stall_cnt_nxt = stall_cnt_r - in_data.cycle_budget;
              end else begin
                out_data_nxt.cycles_left = in_data.cycle_budget - stall_cnt_r;
                stall_cnt_nxt = '0;
              end
            end
            default: begin
              stall_cnt_nxt = '0;
            end
          endcase
        end
      end
      default: begin
        if (out_free) begin
          mem_cmd.capture = 1'b1;
          out_valid_nxt   = 1'b1;
          out_data_nxt.read_data   = field;
          out_data_nxt.cycles_left = '0;
          stall_cnt_nxt   = stall_add;
          adv_we          = post_inc_r;
          state_nxt       = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      stall_cnt_r <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        addr_hi_r[i] <= '0;
        addr_lo_r[i] <= '0;
        inc_hi_r[i]  <= '0;
        inc_lo_r[i]  <= '0;
        mode_r[i]    <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      stall_cnt_r <= stall_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (ptr_we) begin
        case (ptr_reg)
          bapr_pkg::REG_ADDR_HI: addr_hi_r[ptr_set] <= {7'b0, ptr_val[8:0]};
          bapr_pkg::REG_ADDR_LO: addr_lo_r[ptr_set] <= ptr_val;
          bapr_pkg::REG_INC_HI:  inc_hi_r[ptr_set]  <= ptr_val[8:0];
          bapr_pkg::REG_INC_LO:  inc_lo_r[ptr_set]  <= ptr_val;
          bapr_pkg::REG_MODE:    mode_r[ptr_set]    <= ptr_val[3:0];
          default: ;
        endcase
      end
      if (adv_we) begin
        addr_hi_r[set_r] <= adv_addr[31:16];
        addr_lo_r[set_r] <= adv_addr[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    set_r      <= set_nxt;
    post_inc_r <= post_inc_nxt;
    out_data_r <= out_data_nxt;
  end

  bapr_word_port #(
    .RAM_WORDS(RAM_WORDS)
  ) u_word_port (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (mem_cmd),
    .rd_idx(rd_idx),
    .field (field)
  );

endmodule

[rtl/bapr_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bapr_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input bapr_pkg::bapr_in_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input bapr_pkg::bapr_out_t out_data
);

  logic accept;
  logic is_data;

  assign accept  = in_valid && !in_stall;
  assign is_data = (in_data.reg_addr[2:1] == 2'b11);

  // writes return an all-zero item right away
  `ASSERT_NEXT(a_write_result, clk, rst_n, accept && in_data.req_type == bapr_pkg::REQ_WRITE, out_valid && out_data == '0)

  // a data read holds off the next item while the RAM is read
  `ASSERT_NEXT(a_fetch_blocks, clk, rst_n, accept && in_data.req_type == bapr_pkg::REQ_READ && is_data, in_stall && !out_valid)

  // the dummy register reads zero
  `ASSERT_NEXT(a_dummy_zero, clk, rst_n, accept && in_data.req_type == bapr_pkg::REQ_READ && in_data.reg_addr[2:0] == bapr_pkg::REG_DUMMY, out_valid && out_data == '0)

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

endmodule

bind bit_addressed_pointer_ram_port_top bapr_checker u_bapr_checker (.*);

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  bapr_pkg::bapr_in_t  in_data;
  logic                out_valid;
  logic                out_stall;
  bapr_pkg::bapr_out_t out_data;

  bit gaps_on = 1'b1;

  // shadow of the port state
  logic [15:0] ptr_regs [32];
  logic [31:0] ram_model [int unsigned];  // only words that were written
  logic [15:0] last_idx;
  logic [31:0] last_word;
  logic [31:0] last_mask;
  logic [4:0]  last_shift;
  logic [15:0] stall_cnt;
  logic [15:0] stall_peak;

  bapr_pkg::bapr_out_t pending_responses [$];

  int items_sent;
  int results_checked;
  int fails;
  int field_reads;
  int field_writes;

  bit_addressed_pointer_ram_port_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic bapr_pkg::bapr_in_t make_item(input logic [1:0] kind,
                                                   input logic [4:0] ra,
                                                   input logic [15:0] wd, input logic rmw,
                                                   input logic [15:0] budget);
    bapr_pkg::bapr_in_t it;
    it.req_type     = kind;
    it.reg_addr     = ra;
    it.write_data   = wd;
    it.rmw_access   = rmw;
    it.cycle_budget = budget;
    return it;
  endfunction

  // word index the set's bit address points at (RAM of 65536 words)
  function automatic logic [15:0] word_of_set(input logic [4:0] base);
    logic [31:0] a;
    a = {ptr_regs[base], ptr_regs[base + 5'd1]};
    return a[20:5];
  endfunction

  function automatic void bump_stall();
    if (17'(stall_cnt) + bapr_pkg::STALL_PER_ACCESS > bapr_pkg::STALL_MAX)
      stall_cnt = bapr_pkg::STALL_MAX;
    else stall_cnt = stall_cnt + bapr_pkg::STALL_PER_ACCESS;
    if (stall_cnt > stall_peak) stall_peak = stall_cnt;
  endfunction

  function automatic bapr_pkg::bapr_out_t port_response(input bapr_pkg::bapr_in_t it);
    bapr_pkg::bapr_out_t r;
    logic [4:0]  base;
    logic [2:0]  rg;
    logic [2:0]  sz;
    logic [31:0] a;
    logic [31:0] w;
    logic [31:0] m;
    logic [4:0]  sh;
    int          fw;
    r    = '0;
    rg   = it.reg_addr[2:0];
    base = {it.reg_addr[4:3], 3'b000};
    case (it.req_type)
      bapr_pkg::REQ_READ: begin
        if (rg != bapr_pkg::REG_DATA && rg != bapr_pkg::REG_DATA_INC) begin
          r.read_data = ptr_regs[it.reg_addr];
        end else begin
          a  = {ptr_regs[base], ptr_regs[base + 5'd1]};
          sz = ptr_regs[base + 5'd4][2:0];
          fw = (sz > 3'd3) ? 16 : (1 << sz);
          last_idx   = a[20:5];
          w          = ram_model.exists(last_idx) ? ram_model[last_idx] : 32'h0;
          // bit address 0 is the MSB; shift snaps to the field size
          sh         = (5'd31 - a[4:0]) & ~5'(fw - 1);
          m          = ((32'd1 << fw) - 32'd1) << sh;
          last_word  = w;
          last_mask  = m;
          last_shift = sh;
          r.read_data = 16'((w & m) >> sh);
          bump_stall();
          field_reads++;
          if (rg == bapr_pkg::REG_DATA_INC &&
              (!ptr_regs[base + 5'd4][3] || it.rmw_access)) begin
            a = a + {ptr_regs[base + 5'd2], ptr_regs[base + 5'd3]};
            ptr_regs[base]        = a[31:16];
            ptr_regs[base + 5'd1] = a[15:0];
          end
        end
      end
      bapr_pkg::REQ_WRITE: begin
        case (rg)
          bapr_pkg::REG_ADDR_HI, bapr_pkg::REG_INC_HI:
            ptr_regs[it.reg_addr] = it.write_data & 16'h01FF;
          bapr_pkg::REG_ADDR_LO, bapr_pkg::REG_INC_LO:
            ptr_regs[it.reg_addr] = it.write_data;
          bapr_pkg::REG_MODE:
            ptr_regs[it.reg_addr] = it.write_data & 16'h000F;
          bapr_pkg::REG_DUMMY:
            ptr_regs[it.reg_addr] = 16'h0000;
          default: begin
            ram_model[last_idx] = (last_word & ~last_mask) |
                                  ((32'(it.write_data) << last_shift) & last_mask);
            bump_stall();
            field_writes++;
          end
        endcase
      end
      bapr_pkg::REQ_CONSUME: begin
        if (stall_cnt > it.cycle_budget) begin
          stall_cnt = stall_cnt - it.cycle_budget;
        end else begin
          r.cycles_left = it.cycle_budget - stall_cnt;
          stall_cnt     = 16'h0000;
        end
      end
      default: stall_cnt = 16'h0000;
    endcase
    return r;
  endfunction

  task automatic drive_item(input bapr_pkg::bapr_in_t item);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    // all earlier items are in, so the shadow state is current
    pending_responses.push_back(port_response(item));
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // never lets a field read land on a RAM word that holds nothing yet
  task automatic send_item(input bapr_pkg::bapr_in_t item);
    logic [4:0]  base;
    int unsigned w;
    base = {item.reg_addr[4:3], 3'b000};
    if (item.req_type == bapr_pkg::REQ_READ && item.reg_addr[2:1] == 2'b11 &&
        !ram_model.exists(word_of_set(base))) begin
      if (ram_model.num() == 0) begin
        item.req_type = bapr_pkg::REQ_WRITE;
      end else begin
        void'(ram_model.first(w));
        drive_item(make_item(bapr_pkg::REQ_WRITE, {item.reg_addr[4:3], bapr_pkg::REG_ADDR_HI},
                             (16'($urandom) & 16'hFFE0) | 16'(w >> 11), 1'($urandom),
                             16'($urandom)));
        drive_item(make_item(bapr_pkg::REQ_WRITE, {item.reg_addr[4:3], bapr_pkg::REG_ADDR_LO},
                             {w[10:0], 5'($urandom)}, 1'($urandom), 16'($urandom)));
      end
    end
    drive_item(item);
  endtask

  task automatic reg_write(input logic [4:0] ra, input logic [15:0] wd);
    send_item(make_item(bapr_pkg::REQ_WRITE, ra, wd, 1'($urandom), 16'($urandom)));
  endtask

  task automatic reg_read(input logic [4:0] ra, input logic rmw);
    send_item(make_item(bapr_pkg::REQ_READ, ra, 16'($urandom), rmw, 16'($urandom)));
  endtask

  task automatic consume(input logic [15:0] budget);
    send_item(make_item(bapr_pkg::REQ_CONSUME, 5'($urandom), 16'($urandom), 1'($urandom),
                        budget));
  endtask

  task automatic clear_stall();
    send_item(make_item(bapr_pkg::REQ_CLEAR, 5'($urandom), 16'($urandom), 1'($urandom),
                        16'($urandom)));
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic test_write_before_read();
    // nothing read yet: saved mask is zero, so word 0 is written as zero
    reg_write({2'd0, bapr_pkg::REG_DATA}, 16'hFFFF);
    reg_read({2'd0, bapr_pkg::REG_DATA}, 1'b0);
    consume(16'd1);
    consume(16'd3);
  endtask

  task automatic test_register_masks();
    for (int r = 0; r < 6; r++) reg_write({2'd3, 3'(r)}, 16'hFFFF);
    for (int r = 0; r < 6; r++) reg_read({2'd3, 3'(r)}, 1'b0);
  endtask

  task automatic test_field_sizes();
    reg_write({2'd1, bapr_pkg::REG_MODE}, 16'h0004);
    reg_write({2'd1, bapr_pkg::REG_ADDR_HI}, 16'h01E0);
    reg_write({2'd1, bapr_pkg::REG_ADDR_LO}, 16'h0000);
    reg_read({2'd1, bapr_pkg::REG_DATA}, 1'b1);
    reg_write({2'd1, bapr_pkg::REG_DATA}, 16'hA5C3);
    reg_write({2'd1, bapr_pkg::REG_ADDR_LO}, 16'h0010);
    reg_read({2'd1, bapr_pkg::REG_DATA}, 1'b1);
    reg_write({2'd1, bapr_pkg::REG_DATA}, 16'h1E7F);
    for (int sz = 0; sz < 8; sz++) begin
      reg_write({2'd1, bapr_pkg::REG_MODE}, (16'($urandom) & 16'hFFF0) | 16'(sz));
      reg_write({2'd1, bapr_pkg::REG_ADDR_LO},
                (sz == 0) ? 16'd31 : 16'($urandom_range(0, 31)));
      reg_read({2'd1, bapr_pkg::REG_DATA}, 1'($urandom));
    end
  endtask

  task automatic test_post_increment();
    reg_write({2'd2, bapr_pkg::REG_INC_HI}, 16'h0020);
    reg_write({2'd2, bapr_pkg::REG_INC_LO}, 16'h0003);
    reg_write({2'd2, bapr_pkg::REG_ADDR_HI}, 16'h0000);
    reg_write({2'd2, bapr_pkg::REG_ADDR_LO}, 16'h0004);
    reg_write({2'd2, bapr_pkg::REG_MODE}, 16'h000A);   // hold mode, 4-bit fields
    reg_read({2'd2, bapr_pkg::REG_DATA_INC}, 1'b0);
    reg_read({2'd2, bapr_pkg::REG_ADDR_LO}, 1'b0);
    reg_read({2'd2, bapr_pkg::REG_DATA_INC}, 1'b1);    // rmw overrides hold
    reg_read({2'd2, bapr_pkg::REG_ADDR_HI}, 1'b0);
    reg_read({2'd2, bapr_pkg::REG_ADDR_LO}, 1'b0);
    reg_write({2'd2, bapr_pkg::REG_MODE}, 16'h0002);
    reg_read({2'd2, bapr_pkg::REG_DATA_INC}, 1'b0);
    reg_read({2'd2, bapr_pkg::REG_ADDR_LO}, 1'b0);
    reg_read({2'd2, bapr_pkg::REG_DATA}, 1'b1);
    reg_read({2'd2, bapr_pkg::REG_ADDR_LO}, 1'b0);
  endtask

  task automatic test_cross_set_write();
    reg_read({2'd1, bapr_pkg::REG_DATA}, 1'b1);
    reg_write({2'd2, bapr_pkg::REG_DATA_INC}, 16'hFFFF);
    reg_read({2'd1, bapr_pkg::REG_DATA}, 1'b0);
    reg_read({2'd0, bapr_pkg::REG_DATA}, 1'b0);
  endtask

  task automatic test_stall_accounting();
    clear_stall();
    repeat (3) reg_read({2'd0, bapr_pkg::REG_DATA}, 1'b0);
    consume(16'd10);
    repeat (3) reg_read({2'd0, bapr_pkg::REG_DATA}, 1'b0);
    consume(16'd2);
    consume(16'd4);
    reg_read({2'd0, bapr_pkg::REG_DATA}, 1'b0);
    clear_stall();
    consume(16'd7);
  endtask

  // increment only touches bits 31:21, so the address walks through the 32-bit wrap
  task automatic test_address_wrap();
    reg_write({2'd0, bapr_pkg::REG_MODE}, 16'h0000);
    reg_write({2'd0, bapr_pkg::REG_INC_HI}, 16'h01E0);
    reg_write({2'd0, bapr_pkg::REG_INC_LO}, 16'h0000);
    reg_write({2'd0, bapr_pkg::REG_ADDR_HI}, 16'h0000);
    reg_write({2'd0, bapr_pkg::REG_ADDR_LO}, 16'($urandom_range(0, 31)));
    for (int i = 0; i < 150; i++) begin
      reg_read({2'd0, bapr_pkg::REG_DATA_INC}, 1'($urandom));
      if (i % 25 == 0) reg_read({2'd0, bapr_pkg::REG_ADDR_HI}, 1'b0);
    end
  endtask

  // back-to-back field writes pile up stall cycles, then a partial and a full payoff
  task automatic test_stall_buildup();
    gaps_on = 1'b0;
    clear_stall();
    repeat (120) reg_write({2'($urandom), bapr_pkg::REG_DATA}, 16'($urandom));
    consume(16'd100);
    consume(16'h0200);
    gaps_on = 1'b1;
  endtask

  task automatic field_burst(input logic [1:0] s);
    int n;
    if ($urandom_range(0, 2) != 0) begin
      reg_write({s, bapr_pkg::REG_MODE}, 16'($urandom));
      if ($urandom_range(0, 1) != 0) begin
        case ($urandom_range(0, 3))
          0: begin
            reg_write({s, bapr_pkg::REG_INC_HI}, 16'h0000);
            reg_write({s, bapr_pkg::REG_INC_LO}, 16'(1 << $urandom_range(0, 4)));
          end
          1: begin
            reg_write({s, bapr_pkg::REG_INC_HI}, 16'($urandom_range(0, 15)) << 5);
            reg_write({s, bapr_pkg::REG_INC_LO}, 16'($urandom_range(0, 7)));
          end
          2: begin
            reg_write({s, bapr_pkg::REG_INC_HI}, 16'($urandom));
            reg_write({s, bapr_pkg::REG_INC_LO}, 16'($urandom));
          end
          default: begin
            reg_write({s, bapr_pkg::REG_INC_HI}, 16'h0000);
            reg_write({s, bapr_pkg::REG_INC_LO}, 16'h0000);
          end
        endcase
      end
      if ($urandom_range(0, 1) != 0) begin
        reg_write({s, bapr_pkg::REG_ADDR_HI}, 16'($urandom) & 16'hFFE0);
        reg_write({s, bapr_pkg::REG_ADDR_LO}, 16'($urandom_range(0, 31)));
      end
    end
    n = $urandom_range(2, 12);
    repeat (n) begin
      case ($urandom_range(0, 3))
        0: reg_read({s, 2'b11, 1'($urandom)}, 1'($urandom));
        1: begin
          reg_read({s, 2'b11, 1'($urandom)}, 1'b1);
          reg_write({s, 2'b11, 1'($urandom)}, 16'($urandom));
        end
        2: reg_write({s, 2'b11, 1'($urandom)}, 16'($urandom));
        default: reg_read({s, 2'b00, 1'($urandom)}, 1'($urandom));
      endcase
    end
  endtask

  task automatic stall_burst();
    int d;
    case ($urandom_range(0, 4))
      0: clear_stall();
      1: consume(16'($urandom));
      2: begin
        // land on, just under or just over the pending count
        d = int'(stall_cnt) + $urandom_range(0, 4) - 2;
        consume(16'((d < 0) ? 0 : d));
      end
      3: consume(16'h0000);
      default: consume(16'hFFFF);
    endcase
  endtask

  task automatic test_random_traffic(input int target);
    int start;
    int kind;
    start = items_sent;
    while (items_sent - start < target) begin
      if ($urandom_range(0, 15) == 0) gaps_on = ($urandom_range(0, 2) != 0);
      kind = $urandom_range(0, 9);
      if (kind < 5) field_burst(2'($urandom));
      else if (kind < 7) stall_burst();
      else if (kind < 9) send_item(make_item(2'($urandom_range(0, 1)), 5'($urandom),
                                             16'($urandom), 1'($urandom), 16'($urandom)));
      else send_item(make_item(2'($urandom), 5'($urandom), 16'($urandom), 1'($urandom),
                               16'($urandom)));
      if ($urandom_range(0, 299) == 0) wait_all_results();
    end
    gaps_on = 1'b1;
  endtask

  always @(posedge clk) begin : result_check
    bapr_pkg::bapr_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_responses.size() == 0) begin
        $error("unexpected result: read_data=%h cycles_left=%h",
               out_data.read_data, out_data.cycles_left);
        fails++;
      end else begin
        want = pending_responses.pop_front();
        if (out_data.read_data !== want.read_data) begin
          $error("read_data: expected %h, got %h", want.read_data, out_data.read_data);
          fails++;
        end
        if (out_data.cycles_left !== want.cycles_left) begin
          $error("cycles_left: expected %h, got %h", want.cycles_left,
                 out_data.cycles_left);
          fails++;
        end
        results_checked++;
      end
    end
  end

  initial begin : receiver_idle
    int n;
    out_stall = 1'b0;
    forever begin
      repeat ($urandom_range(1, 10)) @(posedge clk);
      n = idle_len();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #40_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    foreach (ptr_regs[i]) ptr_regs[i] = 16'h0000;
    last_idx   = '0;
    last_word  = '0;
    last_mask  = '0;
    last_shift = '0;
    stall_cnt  = '0;
    stall_peak = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_write_before_read();
    test_register_masks();
    test_field_sizes();
    wait_all_results();
    test_post_increment();
    test_cross_set_write();
    test_stall_accounting();
    wait_all_results();
    test_address_wrap();
    wait_all_results();
    test_stall_buildup();
    wait_all_results();
    test_random_traffic(1590);
    wait_all_results();

    $display("Covered %0d items and %0d results: %0d field reads, %0d field writes,",
             items_sent, results_checked, field_reads, field_writes);
    $display("  all register masks, address wrap, stall counter peak %0d.", stall_peak);
    if (fails == 0 && pending_responses.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
